@@ hdl/handle_to_candidate_hash_map_core_macros.svh @@
// Assertion macros for the handle-to-candidate hash map core.
`ifndef HANDLE_TO_CANDIDATE_HASH_MAP_CORE_MACROS_SVH
`define HANDLE_TO_CANDIDATE_HASH_MAP_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define HCMAP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hcmap assertion failed");
`define HCMAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hcmap assertion failed");
`else
`define HCMAP_ASSERT(label, clk, rst_n, prop)
`define HCMAP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/hcmap_pkg.sv @@
// Shared types and constants of the handle-to-candidate hash map.
package hcmap_pkg;

  localparam int unsigned DEF_TABLE_BITS = 14;
  localparam int unsigned DEF_MAX_PROBE  = 64;
  localparam int unsigned DEF_CANDIDATES = 128;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned CAND_W = 8;
  localparam int unsigned OCC_W  = 15;

  localparam logic [KEY_W-1:0]  GOLDEN    = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [CAND_W-1:0] CAND_NONE = 8'hFF;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_DEFINE = 3'd1,
    OP_COPY   = 3'd2,
    OP_UNMAP  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_HASH,
    S_PROBE,
    S_WRITE,
    S_RESP
  } fsm_state_e;

endpackage

@@ hdl/hcmap_hash.sv @@
// Iterative home-slot hash: low 64 bits of key * golden ratio via one 32x32 multiplier.
module hcmap_hash import hcmap_pkg::*; #(
  parameter int unsigned TABLE_BITS = DEF_TABLE_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [KEY_W-1:0]      key_i,
  output logic                  done_o,
  output logic [TABLE_BITS-1:0] home_o
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_LAST = 3'd5;

  logic [2:0]       ph_q;
  logic [KEY_W-1:0] key_q;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      prod_q;
  logic [31:0]      acc_q;

  // Only bits 63:32 of the product are needed: lo*lo full, lo*hi and hi*lo low halves.
  always_comb begin
    mul_a = key_q[31:0];
    mul_b = GOLDEN[31:0];
    case (ph_q)
      3'd2:    mul_b = GOLDEN[63:32];
      3'd3:    mul_a = key_q[63:32];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE;
    end else if (start_i) begin
      ph_q <= 3'd1;
    end else if (ph_q == PH_LAST) begin
      ph_q <= PH_IDLE;
    end else if (ph_q != PH_IDLE) begin
      ph_q <= ph_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
      acc_q <= '0;
    end else begin
      case (ph_q)
        3'd2:         acc_q <= acc_q + prod_q[63:32];
        3'd3, 3'd4:   acc_q <= acc_q + prod_q[31:0];
        default: ;
      endcase
    end
    prod_q <= mul_a * mul_b;
  end

  assign done_o = (ph_q == PH_LAST);
  assign home_o = acc_q[31 -: TABLE_BITS];

endmodule

@@ hdl/handle_to_candidate_hash_map_core.sv @@
// Handle-to-candidate hash map: linear-probing table with an iterative hash and a sequencer.
//
// Input channel (in_valid_i / in_stall_o) carries one operation per transaction:
// lookup, define view, copy view, unmap candidate or clear all. Each transaction
// yields exactly one result on the output channel (out_valid_o / out_stall_i):
// the candidate and read-only mark of handle_i after the operation, plus the
// number of occupied slots. One operation is in flight at a time.
// Sequence: the hash runs on the shared 32x32 multiplier, the probe visits one
// slot per cycle (up to MAX_PROBE) on the table's read port, a map adds a write
// state, and the S_RESP state loads the output register. Copy view adds a
// second hash and probe for the source. Unmap and clear sweep every slot of
// the table before the final lookup.
// After reset the block runs a clearing pass over every slot of the table
// with in_stall_o high. The result sits in an output register: the next
// transaction is taken while it waits, and a stalled result holds until taken.
`include "handle_to_candidate_hash_map_core_macros.svh"

module handle_to_candidate_hash_map_core import hcmap_pkg::*; #(
  parameter int unsigned TABLE_BITS = DEF_TABLE_BITS,
  parameter int unsigned MAX_PROBE  = DEF_MAX_PROBE,
  parameter int unsigned CANDIDATES = DEF_CANDIDATES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               opcode_i,
  input  logic [KEY_W-1:0]         handle_i,
  input  logic [KEY_W-1:0]         source_handle_i,
  input  logic signed [CAND_W-1:0] candidate_i,
  input  logic                     read_only_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CAND_W-1:0] found_candidate_o,
  output logic                     found_read_only_o,
  output logic [OCC_W-1:0]         occupied_slots_o
);

  localparam int unsigned SLOTS = 1 << TABLE_BITS;
  localparam int unsigned CNT_W = TABLE_BITS + 1;
  localparam int unsigned PW    = $clog2(MAX_PROBE + 1);
  localparam logic [CNT_W-1:0] WALK_END = CNT_W'(SLOTS);

  // Table storage
  logic [KEY_W-1:0]  key_mem  [SLOTS];
  logic [CAND_W-1:0] cand_mem [SLOTS];
  logic              ro_mem   [SLOTS];

  logic [TABLE_BITS-1:0] rd_addr, wr_addr;
  logic [KEY_W-1:0]      rd_key_q, wr_key;
  logic [CAND_W-1:0]     rd_cand_q, wr_cand;
  logic                  rd_ro_q, wr_ro;
  logic                  wr_key_en, wr_cand_en, wr_ro_en;

  fsm_state_e state_q, state_d;

  // Control registers
  logic [CNT_W-1:0] w_q;
  logic             wv_q;
  logic [PW-1:0]    cnt_q;
  logic             src_phase_q;
  logic [CNT_W-1:0] slot_cnt_q;
  logic             out_valid_q;

  // Payload registers
  logic [2:0]            op_q;
  logic [KEY_W-1:0]      h_q, src_q;
  logic [CAND_W-1:0]     c_q;
  logic                  ro_q;
  logic [TABLE_BITS-1:0] chk_q, home_q, tgt_q, wa_q;
  logic                  new_q;
  logic [CAND_W-1:0]     r_cand_q, out_cand_q;
  logic                  r_ro_q, out_ro_q;
  logic [OCC_W-1:0]      out_occ_q;

  logic                  accept, cand_ok, walk_req, out_free;
  logic [CAND_W-1:0]     cand_norm;
  logic [KEY_W-1:0]      pkey;
  logic                  p_hit, p_empty, p_done, do_map;
  logic                  hs_start, hs_done;
  logic [KEY_W-1:0]      hs_key;
  logic [TABLE_BITS-1:0] hs_home;
  logic [OCC_W+CNT_W-1:0] occ_ext;

  hcmap_hash #(
    .TABLE_BITS(TABLE_BITS)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hs_start),
    .key_i  (hs_key),
    .done_o (hs_done),
    .home_o (hs_home)
  );

  assign accept    = in_valid_i && !in_stall_o;
  assign cand_ok   = !candidate_i[CAND_W-1] && ($unsigned(candidate_i) < CAND_W'(CANDIDATES));
  assign cand_norm = cand_ok ? candidate_i : CAND_NONE;
  assign walk_req  = (opcode_i == OP_CLEAR) || ((opcode_i == OP_UNMAP) && cand_ok);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Probe check on the slot whose data sits in the read register
  assign pkey    = src_phase_q ? src_q : h_q;
  assign p_hit   = (pkey != '0) && (rd_key_q == pkey);
  assign p_empty = (rd_key_q == '0);
  assign p_done  = (pkey == '0) || p_hit || p_empty || (cnt_q == PW'(MAX_PROBE - 1));
  assign do_map  = ((op_q == OP_DEFINE) || (op_q == OP_COPY)) && (h_q != '0) &&
                   (!c_q[CAND_W-1] || (p_hit && !rd_cand_q[CAND_W-1]));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:  if (w_q[TABLE_BITS-1:0] == '1) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = walk_req ? S_WALK : S_HASH;
      S_WALK:  if (w_q == WALK_END) state_d = S_HASH;
      S_HASH:  if (hs_done) state_d = S_PROBE;
      S_PROBE: begin
        if (p_done) begin
          if (src_phase_q)  state_d = S_HASH;
          else if (do_map)  state_d = S_WRITE;
          else              state_d = S_RESP;
        end
      end
      S_WRITE: state_d = S_RESP;
      S_RESP:  if (out_free) state_d = S_IDLE;
      default: state_d = S_INIT;
    endcase
  end

  // Control outputs: table ports and hash start
  always_comb begin
    rd_addr    = chk_q + 1'b1;
    wr_addr    = tgt_q;
    wr_key     = h_q;
    wr_cand    = c_q;
    wr_ro      = ro_q;
    wr_key_en  = 1'b0;
    wr_cand_en = 1'b0;
    wr_ro_en   = 1'b0;
    hs_start   = 1'b0;
    hs_key     = h_q;
    unique case (state_q)
      S_INIT: begin
        wr_addr    = w_q[TABLE_BITS-1:0];
        wr_key     = '0;
        wr_cand    = CAND_NONE;
        wr_ro      = 1'b0;
        wr_key_en  = 1'b1;
        wr_cand_en = 1'b1;
        wr_ro_en   = 1'b1;
      end
      S_IDLE: begin
        hs_start = accept && !walk_req;
        hs_key   = (opcode_i == OP_COPY) ? source_handle_i : handle_i;
      end
      S_WALK: begin
        rd_addr    = w_q[TABLE_BITS-1:0];
        wr_addr    = wa_q;
        wr_cand    = CAND_NONE;
        wr_cand_en = wv_q && ((op_q == OP_CLEAR) || (rd_cand_q == c_q));
        hs_start   = (w_q == WALK_END);
      end
      S_HASH: begin
        rd_addr = hs_home;
      end
      S_PROBE: begin
        hs_start = p_done && src_phase_q;
      end
      S_WRITE: begin
        wr_key_en  = 1'b1;
        wr_cand_en = 1'b1;
        wr_ro_en   = 1'b1;
      end
      S_RESP: ;
      default: ;
    endcase
  end

  // Table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_key_en)  key_mem[wr_addr]  <= wr_key;
    if (wr_cand_en) cand_mem[wr_addr] <= wr_cand;
    if (wr_ro_en)   ro_mem[wr_addr]   <= wr_ro;
    rd_key_q  <= key_mem[rd_addr];
    rd_cand_q <= cand_mem[rd_addr];
    rd_ro_q   <= ro_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      w_q         <= '0;
      wv_q        <= 1'b0;
      cnt_q       <= '0;
      src_phase_q <= 1'b0;
      slot_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wv_q    <= 1'b0;
      unique case (state_q)
        S_INIT: w_q <= w_q + 1'b1;
        S_IDLE: begin
          if (accept) begin
            w_q         <= '0;
            src_phase_q <= (opcode_i == OP_COPY);
          end
        end
        S_WALK: begin
          if (w_q != WALK_END) begin
            w_q  <= w_q + 1'b1;
            wv_q <= 1'b1;
          end
        end
        S_HASH:  cnt_q <= '0;
        S_PROBE: begin
          if (p_done) src_phase_q <= 1'b0;
          else        cnt_q <= cnt_q + 1'b1;
        end
        S_WRITE: if (new_q) slot_cnt_q <= slot_cnt_q + 1'b1;
        S_RESP: ;
        default: ;
      endcase
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, slot_cnt_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= opcode_i;
      h_q   <= handle_i;
      src_q <= source_handle_i;
      c_q   <= cand_norm;
      ro_q  <= read_only_i;
    end
    wa_q <= w_q[TABLE_BITS-1:0];
    if (state_q == S_HASH) begin
      chk_q  <= hs_home;
      home_q <= hs_home;
    end
    if (state_q == S_PROBE) begin
      if (!p_done) begin
        chk_q <= chk_q + 1'b1;
      end else if (src_phase_q) begin
        // source of a copy: its candidate and mark become the view to apply
        c_q  <= p_hit ? rd_cand_q : CAND_NONE;
        ro_q <= p_hit && rd_ro_q;
      end else begin
        tgt_q    <= (p_hit || p_empty) ? chk_q : home_q;
        new_q    <= p_empty && !p_hit;
        r_cand_q <= p_hit ? rd_cand_q : CAND_NONE;
        r_ro_q   <= p_hit && rd_ro_q;
      end
    end
    if (state_q == S_WRITE) begin
      r_cand_q <= c_q;
      r_ro_q   <= ro_q;
    end
    if (state_q == S_RESP && out_free) begin
      out_cand_q <= r_cand_q;
      out_ro_q   <= r_ro_q;
      out_occ_q  <= occ_ext[OCC_W-1:0];
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign found_candidate_o = out_cand_q;
  assign found_read_only_o = out_ro_q;
  assign occupied_slots_o  = out_occ_q;

  `HCMAP_ASSERT(a_key_write_phase, clk_i, rst_ni,
                !wr_key_en || state_q == S_INIT || state_q == S_WRITE)
  `HCMAP_ASSERT(a_probe_bound, clk_i, rst_ni,
                state_q != S_PROBE || cnt_q < PW'(MAX_PROBE))
  `HCMAP_ASSERT_NEXT(a_count_step, clk_i, rst_ni, 1'b1,
                     slot_cnt_q == $past(slot_cnt_q) ||
                     slot_cnt_q == CNT_W'($past(slot_cnt_q) + 1'b1))
  `HCMAP_ASSERT(a_result_from_resp, clk_i, rst_ni,
                !$rose(out_valid_q) || $past(state_q) == S_RESP)

endmodule
